### sv/gpc_pkg.sv
`timescale 1ns / 1ps

package gpc_pkg;

  localparam int PIN_COUNT = 74;
  localparam int PIN_W = $clog2(PIN_COUNT);

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_DRIVE  = 2'd1,
    OP_MODE   = 2'd2,
    OP_ENABLE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DISABLED  = 2'd1,
    ST_UNHANDLED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_A_NOOP,
    CLS_FIXED,
    CLS_OWN,
    CLS_IDE
  } pin_class_t;

  typedef struct packed {
    op_t              op;
    logic [PIN_W-1:0] pin;
    logic             value;
    logic             pad;
  } item_t;

  typedef struct packed {
    logic enable;
    logic tristate;
    logic drive;
  } pin_bits_t;

  typedef struct packed {
    logic             en;
    logic [PIN_W-1:0] addr;
    pin_bits_t        data;
  } wr_req_t;

  typedef struct packed {
    status_t status;
    logic    level;
  } result_t;

  function automatic pin_class_t pin_class(input logic [PIN_W-1:0] p);
    pin_class_t c;
    if (p <= PIN_W'(10)) c = CLS_FIXED;
    else if (p <= PIN_W'(14)) c = CLS_OWN;
    else if (p <= PIN_W'(30)) c = CLS_IDE;
    else if (p <= PIN_W'(37)) c = CLS_OWN;
    else if (p <= PIN_W'(45)) c = CLS_NONE;
    else if (p <= PIN_W'(48)) c = CLS_OWN;
    else if (p <= PIN_W'(64)) c = CLS_A_NOOP;
    else if (p == PIN_W'(67)) c = CLS_OWN;
    else if (p <= PIN_W'(69)) c = CLS_FIXED;
    else if (p <= PIN_W'(73)) c = CLS_OWN;
    else c = CLS_NONE;
    return c;
  endfunction

endpackage

### sv/gpc_ram.sv
`timescale 1ns / 1ps

module gpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/gpc_exec.sv
`timescale 1ns / 1ps

module gpc_exec (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  gpc_pkg::item_t     item,
  input  gpc_pkg::pin_bits_t rdata,
  input  logic               fwd,
  input  gpc_pkg::pin_bits_t fwd_bits,
  output gpc_pkg::result_t   res,
  output gpc_pkg::wr_req_t   wr
);
  import gpc_pkg::*;

  logic [PIN_COUNT-1:0] written;
  logic                 ide_enable;
  logic                 ide_enable_next;
  pin_class_t           cls;
  pin_bits_t            bits;
  pin_bits_t            bits_next;
  logic                 change;
  logic                 usable;

  always_comb begin
    cls = pin_class(item.pin);
    if (fwd) begin
      bits = fwd_bits;
    end else if (cls != CLS_NONE && written[item.pin]) begin
      bits = rdata;
    end else begin
      bits = '0;
    end

    bits_next = bits;
    change = 1'b0;
    ide_enable_next = ide_enable;
    res.status = ST_OK;
    res.level = 1'b0;
    usable = 1'b1;

    if (cls == CLS_NONE) begin
      res.status = ST_UNHANDLED;
    end else if (item.op == OP_ENABLE) begin
      case (cls)
        CLS_OWN: begin
          bits_next.enable = item.value;
          change = 1'b1;
        end
        CLS_IDE: ide_enable_next = item.value;
        CLS_FIXED: res.status = ST_UNHANDLED;
        default: ;
      endcase
    end else begin
      if (cls == CLS_OWN) begin
        usable = bits.enable;
      end else if (cls == CLS_IDE) begin
        usable = ide_enable;
      end
      if (!usable) begin
        res.status = ST_DISABLED;
      end else begin
        case (item.op)
          OP_READ: res.level = bits.tristate ? item.pad : bits.drive;
          OP_DRIVE: begin
            bits_next.drive = item.value;
            change = 1'b1;
          end
          OP_MODE: begin
            bits_next.tristate = item.value;
            change = 1'b1;
          end
          default: ;
        endcase
      end
    end

    wr.en = fire && change;
    wr.addr = item.pin;
    wr.data = bits_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      ide_enable <= 1'b0;
    end else if (fire) begin
      ide_enable <= ide_enable_next;
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
    end
  end

  a_wr_mapped: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (cls == CLS_OWN || cls == CLS_IDE || cls == CLS_FIXED || cls == CLS_A_NOOP))
    else $error("write issued for an unmapped pin");

  a_level_ok: assert property (@(posedge clk) disable iff (rst)
    res.level |-> (res.status == ST_OK && item.op == OP_READ))
    else $error("level set on a failed or non-read transaction");

  a_error_no_write: assert property (@(posedge clk) disable iff (rst)
    (res.status != ST_OK) |-> !wr.en)
    else $error("failed transaction changed pin state");

endmodule

### sv/gpio_pin_controller_top.sv
`timescale 1ns / 1ps
// General-purpose pin controller for pin numbers 0 to 73.
// Command channel: cmd_valid and cmd_stall carry one transaction made of
// operation, pin_number, value and pad_level. A transaction is taken at a
// rising edge where cmd_valid is high and cmd_stall is low.
// Response channel: rsp_valid and rsp_stall carry status and level. Each
// command transaction produces exactly one response transaction, in order.
// rsp_valid rises when the command passes from the execute register s1 to
// the response register, which a stalled response delays. One transaction
// can be taken every cycle as long as responses are taken.
// The per-pin latch, mode and enable bits live in one small RAM with a
// registered read. The read is issued at the accepting edge, the command is
// resolved while it is held in s1, and it is written back at the edge that
// loads its response; back-to-back commands to the same pin are forwarded
// around the RAM.
// When rsp_stall is high, the held response stays stable, the command in
// flight waits behind it, and cmd_stall rises once that command is waiting.
// Reset clears all latches, modes and enables to zero at once (a written
// flag per pin and the IDE enable), and empties both pipeline registers.
module gpio_pin_controller_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  logic [1:0]                operation,
  input  logic [gpc_pkg::PIN_W-1:0] pin_number,
  input  logic                      value,
  input  logic                      pad_level,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic [1:0]                status,
  output logic                      level
);
  import gpc_pkg::*;

  logic             cmd_fire;
  logic             s1_valid;
  logic             s1_fire;
  item_t            s1;
  logic             fwd;
  pin_bits_t        fwd_bits;
  pin_bits_t        rdata;
  logic [PIN_W-1:0] rd_addr;
  result_t          res;
  wr_req_t          wr;

  assign s1_fire = s1_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall = s1_valid && !s1_fire;
  assign cmd_fire = cmd_valid && !cmd_stall;
  assign rd_addr = cmd_fire ? pin_number : s1.pin;

  gpc_ram #(
    .Width($bits(pin_bits_t)),
    .Depth(PIN_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_addr (rd_addr),
    .rd_data (rdata)
  );

  gpc_exec u_exec (
    .clk      (clk),
    .rst      (rst),
    .fire     (s1_fire),
    .item     (s1),
    .rdata    (rdata),
    .fwd      (fwd),
    .fwd_bits (fwd_bits),
    .res      (res),
    .wr       (wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd <= 1'b0;
    end else begin
      if (cmd_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      fwd <= cmd_fire && wr.en && (wr.addr == pin_number);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      s1.op <= op_t'(operation);
      s1.pin <= pin_number;
      s1.value <= value;
      s1.pad <= pad_level;
      fwd_bits <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      status <= res.status;
      level <= res.level;
    end
  end

  a_cmd_loads: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> s1_valid)
    else $error("accepted command did not reach the execute stage");

  a_wr_on_fire: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> s1_fire)
    else $error("RAM written without a completing transaction");

  a_fire_rsp: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> rsp_valid)
    else $error("completed transaction produced no response");

  a_rsp_level: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && level) |-> (status == ST_OK))
    else $error("level reported on a failed response");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gpc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst;
  logic               cmd_valid;
  logic               cmd_stall;
  logic [1:0]         operation;
  logic [PIN_W-1:0]   pin_number;
  logic               value;
  logic               pad_level;
  logic               rsp_valid;
  logic               rsp_stall;
  logic [1:0]         status;
  logic               level;

  bit [PIN_COUNT-1:0] latch_bits;
  bit [PIN_COUNT-1:0] tristate_bits;
  bit [PIN_COUNT-1:0] enable_bits;
  bit                 ide_enabled;
  result_t            pending_results[$];
  int                 error_count = 0;
  int                 cycle_count = 0;
  bit                 sender_no_gaps = 0;
  bit                 receiver_no_gaps = 0;

  gpio_pin_controller_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .operation  (operation),
    .pin_number (pin_number),
    .value      (value),
    .pad_level  (pad_level),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .level      (level)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic pin_class_t classify_pin(input logic [PIN_W-1:0] p);
    if (p > 73 || (p >= 38 && p <= 45)) return CLS_NONE;
    if ((p >= 11 && p <= 14) || (p >= 31 && p <= 37) || (p >= 46 && p <= 48) ||
        p == 67 || p >= 70) return CLS_OWN;
    if (p >= 15 && p <= 30) return CLS_IDE;
    if (p >= 49 && p <= 64) return CLS_A_NOOP;
    return CLS_FIXED;
  endfunction

  function automatic result_t resolve_access(input op_t op, input logic [PIN_W-1:0] pin,
                                             input logic val, input logic pad);
    result_t    r;
    pin_class_t cls;
    bit         usable;
    r.status = ST_OK;
    r.level  = 1'b0;
    cls = classify_pin(pin);
    if (cls == CLS_NONE) begin
      r.status = ST_UNHANDLED;
    end else if (op == OP_ENABLE) begin
      case (cls)
        CLS_OWN: begin
          enable_bits[pin] = val;
        end
        CLS_IDE: begin
          ide_enabled = val;
        end
        CLS_FIXED: begin
          r.status = ST_UNHANDLED;
        end
        default: begin
        end
      endcase
    end else begin
      usable = (cls == CLS_OWN) ? enable_bits[pin] : (cls == CLS_IDE) ? ide_enabled : 1'b1;
      if (!usable) begin
        r.status = ST_DISABLED;
      end else begin
        case (op)
          OP_READ: begin
            r.level = tristate_bits[pin] ? pad : latch_bits[pin];
          end
          OP_DRIVE: begin
            latch_bits[pin] = val;
          end
          default: begin
            tristate_bits[pin] = val;
          end
        endcase
      end
    end
    return r;
  endfunction

  task automatic send_access(input op_t op, input int pin, input bit val, input bit pad);
    int gap;
    gap = sender_no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid  <= 1'b1;
    operation  <= op;
    pin_number <= pin[PIN_W-1:0];
    value      <= val;
    pad_level  <= pad;
    do @(posedge clk); while (cmd_stall !== 1'b0);
    pending_results.push_back(resolve_access(op, pin[PIN_W-1:0], val, pad));
  endtask

  task automatic wait_for_results();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  initial begin
    int      hold;
    result_t want;
    hold = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
        if (pending_results.size() == 0) begin
          $error("unexpected response transaction: status %0d level %0d", status, level);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status);
            error_count++;
          end
          if (level !== want.level) begin
            $error("level mismatch: expected %0d, got %0d", want.level, level);
            error_count++;
          end
        end
        hold = receiver_no_gaps ? 0 : $urandom_range(0, 15);
      end
      rsp_stall <= (hold > 0);
      if (hold > 0) hold--;
    end
  end

  task automatic test_fixed_and_group_a_pins();
    send_access(OP_READ, 0, 1'b0, 1'b1);
    send_access(OP_DRIVE, 0, 1'b1, 1'b0);
    send_access(OP_READ, 0, 1'b0, 1'b0);
    send_access(OP_MODE, 0, 1'b1, 1'b0);
    send_access(OP_READ, 0, 1'b0, 1'b1);
    send_access(OP_READ, 0, 1'b0, 1'b0);
    send_access(OP_DRIVE, 64, 1'b1, 1'b0);
    send_access(OP_READ, 64, 1'b0, 1'b0);
  endtask

  task automatic test_unmapped_pins();
    send_access(OP_READ, 38, 1'b1, 1'b1);
    send_access(OP_DRIVE, 45, 1'b1, 1'b1);
    send_access(OP_ENABLE, 74, 1'b1, 1'b0);
    send_access(OP_MODE, 127, 1'b1, 1'b1);
  endtask

  task automatic test_enable_rules();
    send_access(OP_READ, 11, 1'b0, 1'b1);
    send_access(OP_DRIVE, 15, 1'b1, 1'b0);
    send_access(OP_ENABLE, 11, 1'b1, 1'b0);
    send_access(OP_DRIVE, 11, 1'b1, 1'b0);
    send_access(OP_READ, 11, 1'b0, 1'b0);
    send_access(OP_ENABLE, 20, 1'b1, 1'b0);
    send_access(OP_MODE, 15, 1'b1, 1'b0);
    send_access(OP_READ, 15, 1'b0, 1'b1);
    send_access(OP_ENABLE, 49, 1'b1, 1'b0);
    send_access(OP_ENABLE, 4, 1'b1, 1'b0);
    send_access(OP_ENABLE, 69, 1'b1, 1'b0);
    send_access(OP_ENABLE, 73, 1'b1, 1'b0);
    send_access(OP_ENABLE, 11, 1'b0, 1'b0);
    send_access(OP_READ, 11, 1'b0, 1'b0);
  endtask

  task automatic run_pin_traffic(input int count);
    int  sent;
    int  pin;
    int  burst;
    op_t op;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 15) begin
        op = op_t'($urandom_range(0, 3));
        send_access(op, int'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        sent++;
      end else begin
        do pin = int'($urandom_range(0, 73)); while (pin >= 38 && pin <= 45);
        if ($urandom_range(0, 9) < 8) begin
          send_access(OP_ENABLE, pin, $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
          sent++;
        end
        burst = int'($urandom_range(2, 6));
        repeat (burst) begin
          op = op_t'($urandom_range(0, 2));
          send_access(op, pin, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          sent++;
        end
      end
      if ($urandom_range(0, 199) == 0) wait_for_results();
    end
  endtask

  task automatic test_mixed_traffic();
    run_pin_traffic(800);
  endtask

  task automatic test_back_to_back_traffic();
    sender_no_gaps   = 1;
    receiver_no_gaps = 1;
    run_pin_traffic(250);
    sender_no_gaps   = 0;
    receiver_no_gaps = 0;
  endtask

  task automatic test_response_backpressure();
    sender_no_gaps = 1;
    run_pin_traffic(200);
    sender_no_gaps = 0;
  endtask

  initial begin
    rst        <= 1'b1;
    cmd_valid  <= 1'b0;
    operation  <= OP_READ;
    pin_number <= '0;
    value      <= 1'b0;
    pad_level  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_fixed_and_group_a_pins();
    test_unmapped_pins();
    test_enable_rules();
    wait_for_results();
    test_mixed_traffic();
    test_back_to_back_traffic();
    wait_for_results();
    test_response_backpressure();
    wait_for_results();
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### sim.f
sv/gpc_pkg.sv
sv/gpc_ram.sv
sv/gpc_exec.sv
sv/gpio_pin_controller_top.sv
dv/testbench.sv
